[rtl/gf2_partial_linear_map_closure_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the GF(2) partial linear map closure unit
// Checks are compiled in simulation only; synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef GF2_PARTIAL_LINEAR_MAP_CLOSURE_UNIT_DEFINES_SVH
`define GF2_PARTIAL_LINEAR_MAP_CLOSURE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// invariant checked every clock outside reset
`define GF2PLMC_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);

// same-cycle implication checked every clock outside reset
`define GF2PLMC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

`else

`define GF2PLMC_ASSERT(lbl, clk_i, rstn_i, prop, msg)

`define GF2PLMC_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons, msg)

`endif

`endif

[rtl/gf2plmc_pkg.sv]
// ----------------------------------------------------------------------------
// gf2plmc_pkg
// Types and codes shared by the GF(2) partial linear map closure unit.
// ----------------------------------------------------------------------------
package gf2plmc_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int IDX_W       = 7;
  localparam int CNT_W       = 8;

  localparam logic [2:0] SIZE_LOG2_RESET   = 3'd7;
  localparam logic       REG_IDX_SIZE_LOG2 = 1'b0;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_KNOWN   = 3'd1,
    ST_CONTRA  = 3'd2,
    ST_FOUND   = 3'd3,
    ST_NOTSET  = 3'd4,
    ST_CLEARED = 3'd5,
    ST_RANGE   = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] in_x;
    logic [IDX_W-1:0] in_y;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             pair_valid;
    logic [IDX_W-1:0] out_x;
    logic [IDX_W-1:0] out_y;
    logic [CNT_W-1:0] lowest_unset;
    logic             complete;
    logic             last;
  } out_word_t;

endpackage

[rtl/gf2_partial_linear_map_closure_unit.sv]
// ----------------------------------------------------------------------------
// gf2_partial_linear_map_closure_unit
// Partially known injective linear map on GF(2)^n: value memory plus known
// marks, closed under XOR whenever a new pair is added.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | word
//  in_     | in  | in_valid / in_ready   | command, in_x, in_y
//  out_    | out | out_valid / out_ready | status, pair, lowest unset, flags
//  cfg     | in  | psel/penable, pready  | size_log2 at byte address 0
//
//  One word at a time. Clear, out-of-range, mismatch and unset-lookup words go
//  straight to the response; other lookups and adds of a known x first do one
//  memory read. Add of a new x: image scan, lowest-unset walk, write pass over
//  the coset of the known entries, then idle; a separate result word follows
//  only when nothing is derived.
//  Output stalls hold the write pass; a result word waits in the output reg.
//  Reset and any size_log2 write clear the table.
// ----------------------------------------------------------------------------
`include "gf2_partial_linear_map_closure_unit_defines.svh"

module gf2_partial_linear_map_closure_unit #(
  parameter int TABLE_SIZE = 128
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  gf2plmc_pkg::in_word_t   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output gf2plmc_pkg::out_word_t  out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import gf2plmc_pkg::*;

  localparam int         MAX_LOG2   = $clog2(TABLE_SIZE + 1) - 1;
  localparam logic [2:0] MAX_LOG2_L = 3'(MAX_LOG2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDX,
    S_CHECK,
    S_WALK,
    S_WR_ISSUE,
    S_WR_DATA,
    S_RESP
  } state_t;

  state_t             state_r;
  logic [1:0]         cmd_r;
  logic [IDX_W-1:0]   x_r;
  logic [IDX_W-1:0]   y_r;
  logic [CNT_W-1:0]   e_r;
  logic               rd_pend_r;
  logic [CNT_W-1:0]   rem_r;
  logic               none_r;
  logic [2:0]         res_status_r;
  logic               res_pv_r;
  logic [IDX_W-1:0]   res_x_r;
  logic [IDX_W-1:0]   res_y_r;
  logic [CNT_W-1:0]   lu_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STORE_DEPTH-1:0] known_r;
  logic [2:0]         size_log2_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic [IDX_W-1:0]   mem [0:STORE_DEPTH-1];
  logic [IDX_W-1:0]   rd_q_r;
  logic [IDX_W-1:0]   rd_addr_r;

  logic [2:0]         n_eff;
  logic [CNT_W-1:0]   size_w;
  logic [IDX_W-1:0]   e_idx;
  logic [IDX_W-1:0]   pair_idx;
  logic               e_in;
  logic               old_e;
  logic [IDX_W-1:0]   walk_idx;
  logic               walk_set;
  logic               can_load;
  logic               cfg_wr;
  logic               in_acc;
  logic [IDX_W-1:0]   mem_q;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [IDX_W-1:0]   mem_wr_data;

  always_comb begin
    n_eff = (size_log2_r == 3'd0) ? 3'd1 : size_log2_r;
    if (n_eff > MAX_LOG2_L) begin
      n_eff = MAX_LOG2_L;
    end
  end
  assign size_w = CNT_W'(1) << n_eff;

  assign e_idx    = e_r[IDX_W-1:0];
  assign pair_idx = e_idx ^ x_r;
  assign e_in     = (e_r < size_w);
  // entry of the subspace before this add: its coset partner is not yet set
  assign old_e    = known_r[e_idx] & ~known_r[pair_idx];
  // known marks as they will be once the closure is written
  assign walk_idx = lu_r[IDX_W-1:0];
  assign walk_set = known_r[walk_idx] | known_r[walk_idx ^ x_r];

  assign can_load = !out_valid_r || out_ready;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_IDX_SIZE_LOG2);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign prdata    = {29'd0, size_log2_r};
  assign pready    = 1'b1;

  // entry 0 is never stored; it always maps to 0
  assign mem_q = (rd_addr_r == '0) ? '0 : rd_q_r;

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = e_idx;
    case (state_r)
      S_IDLE: begin
        mem_rd_en   = in_acc;
        mem_rd_addr = in_data.in_x;
      end
      S_CHECK:    mem_rd_en = e_in;
      S_WR_ISSUE: mem_rd_en = e_in && old_e;
      default:    mem_rd_en = 1'b0;
    endcase
  end

  // reads hit the old subspace, writes its coset: no same-entry overlap
  assign mem_wr_en   = (state_r == S_WR_DATA);
  assign mem_wr_addr = pair_idx;
  assign mem_wr_data = mem_q ^ y_r;

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_q_r    <= mem[mem_rd_addr];
      rd_addr_r <= mem_rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_log2_r <= SIZE_LOG2_RESET;
      known_r     <= STORE_DEPTH'(1);
      lu_r        <= CNT_W'(1);
      cnt_r       <= CNT_W'(1);
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        size_log2_r <= pwdata[2:0];
        known_r     <= STORE_DEPTH'(1);
        lu_r        <= CNT_W'(1);
        cnt_r       <= CNT_W'(1);
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r    <= in_data.command;
            x_r      <= in_data.in_x;
            y_r      <= in_data.in_y;
            res_pv_r <= 1'b0;
            res_x_r  <= '0;
            res_y_r  <= '0;
            state_r  <= S_RESP;
            case (in_data.command)
              CMD_CLEAR: begin
                known_r      <= STORE_DEPTH'(1);
                lu_r         <= CNT_W'(1);
                cnt_r        <= CNT_W'(1);
                res_status_r <= ST_CLEARED;
              end
              CMD_LOOKUP: begin
                if ({1'b0, in_data.in_x} >= size_w) begin
                  res_status_r <= ST_RANGE;
                end else if (known_r[in_data.in_x]) begin
                  state_r <= S_RDX;
                end else begin
                  res_status_r <= ST_NOTSET;
                  res_x_r      <= in_data.in_x;
                end
              end
              CMD_ADD: begin
                if (({1'b0, in_data.in_x} >= size_w) ||
                    ({1'b0, in_data.in_y} >= size_w)) begin
                  res_status_r <= ST_RANGE;
                end else if ((in_data.in_x == '0) != (in_data.in_y == '0)) begin
                  res_status_r <= ST_CONTRA;
                end else if (known_r[in_data.in_x]) begin
                  state_r <= S_RDX;
                end else begin
                  e_r       <= '0;
                  rd_pend_r <= 1'b0;
                  state_r   <= S_CHECK;
                end
              end
              default: res_status_r <= ST_RANGE;
            endcase
          end
        end

        S_RDX: begin
          if (cmd_r == CMD_LOOKUP) begin
            res_status_r <= ST_FOUND;
            res_pv_r     <= 1'b1;
            res_x_r      <= x_r;
            res_y_r      <= mem_q;
          end else begin
            res_status_r <= (mem_q == y_r) ? ST_KNOWN : ST_CONTRA;
          end
          state_r <= S_RESP;
        end

        // scan all known images for y: a hit would map a nonzero word to 0
        S_CHECK: begin
          rd_pend_r <= e_in && known_r[e_idx];
          if (e_in) begin
            e_r <= e_r + CNT_W'(1);
          end
          if (rd_pend_r && (mem_q == y_r)) begin
            res_status_r <= ST_CONTRA;
            rd_pend_r    <= 1'b0;
            state_r      <= S_RESP;
          end else if (!e_in && !rd_pend_r) begin
            rem_r   <= cnt_r - CNT_W'(1);
            none_r  <= (cnt_r == CNT_W'(1));
            cnt_r   <= cnt_r << 1;
            e_r     <= '0;
            state_r <= S_WALK;
          end
        end

        S_WALK: begin
          if ((lu_r < size_w) && walk_set) begin
            lu_r <= lu_r + CNT_W'(1);
          end else begin
            state_r <= S_WR_ISSUE;
          end
        end

        S_WR_ISSUE: begin
          if (!e_in) begin
            if (none_r) begin
              res_status_r <= ST_ADDED;
              state_r      <= S_RESP;
            end else begin
              state_r <= S_IDLE;
            end
          end else if (old_e) begin
            known_r[pair_idx] <= 1'b1;
            state_r           <= S_WR_DATA;
          end else begin
            e_r <= e_r + CNT_W'(1);
          end
        end

        // write the derived pair; emit it unless it came from entry 0
        S_WR_DATA: begin
          if (e_idx == '0) begin
            e_r     <= e_r + CNT_W'(1);
            state_r <= S_WR_ISSUE;
          end else if (can_load) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= ST_ADDED;
            out_data_r.pair_valid   <= 1'b1;
            out_data_r.out_x        <= pair_idx;
            out_data_r.out_y        <= mem_wr_data;
            out_data_r.lowest_unset <= lu_r;
            out_data_r.complete     <= (cnt_r == size_w);
            out_data_r.last         <= (rem_r == CNT_W'(1));
            rem_r                   <= rem_r - CNT_W'(1);
            e_r                     <= e_r + CNT_W'(1);
            state_r                 <= S_WR_ISSUE;
          end
        end

        S_RESP: begin
          if (can_load) begin
            out_valid_r             <= 1'b1;
            out_data_r.status       <= res_status_r;
            out_data_r.pair_valid   <= res_pv_r;
            out_data_r.out_x        <= res_x_r;
            out_data_r.out_y        <= res_y_r;
            out_data_r.lowest_unset <= lu_r;
            out_data_r.complete     <= (cnt_r == size_w);
            out_data_r.last         <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // known set is a subspace, so its size stays a power of two
  `GF2PLMC_ASSERT(a_count_pow2, clk, rst_n, $onehot(cnt_r), "known count not a power of two")

  `GF2PLMC_ASSERT_IMPL(a_no_zero_write, clk, rst_n, mem_wr_en, mem_wr_addr != '0,
                       "closure wrote entry 0")

  `GF2PLMC_ASSERT_IMPL(a_mid_word_pair, clk, rst_n, out_valid && !out_data.last,
                       (out_data.status == ST_ADDED) && out_data.pair_valid,
                       "non-final word is not a derived pair")

endmodule
